// ----- sv/sample_set_statistics_top_macros.svh -----
// Assertion helpers for the statistics block
`ifndef SAMPLE_SET_STATISTICS_TOP_MACROS_SVH
`define SAMPLE_SET_STATISTICS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
`define SSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define SSS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/sss_pkg.sv -----
`default_nettype none
package sss_pkg;
    localparam int MAX_SAMPLES = 256;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 32 + $clog2(MAX_SAMPLES);
    localparam int Q_W = 64 + $clog2(MAX_SAMPLES);
    localparam int NUM_W = Q_W + CNT_W;
    localparam int DEN_W = 2 * CNT_W;
    localparam int PCT_W = 17;
    localparam logic [PCT_W-1:0] PCT_ONE = 17'h10000;
    localparam logic [PCT_W-1:0] PCT_RESET = 17'h08000;
    localparam logic [0:0] ADDR_PCT = 1'b0;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               last_sample;
    } t_in;

    typedef struct packed {
        logic [8:0]         sample_count;
        logic signed [31:0] mean_value;
        logic signed [31:0] median_value;
        logic [31:0]        std_deviation;
        logic signed [31:0] minimum_value;
        logic signed [31:0] maximum_value;
        logic signed [31:0] percentile_value;
        logic               overflow_flag;
    } t_out;

    typedef struct packed {
        logic               ins;
        logic               shift;
        logic signed [31:0] x;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [31:0] val;
        logic               valid;
        logic               gt;
    } t_cell_link;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;
endpackage
`default_nettype wire

// ----- sv/sss_cell.sv -----
`default_nettype none
module sss_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sss_pkg::t_cell_ctl  i_ctl,
    input  wire sss_pkg::t_cell_link i_prev,
    input  wire sss_pkg::t_cell_link i_next,
    output sss_pkg::t_cell_link      o_self
);
    logic signed [31:0] r_val;
    logic               r_valid;
    logic               w_gt;
    logic               w_load;

    assign w_gt = r_valid && (r_val > i_ctl.x);
    // take a value if ours moves up, or if we are the first free slot
    assign w_load = w_gt || (!r_valid && i_prev.valid);
    assign o_self = '{val: r_val, valid: r_valid, gt: w_gt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (w_load) r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_load) begin
            r_val <= i_prev.gt ? i_prev.val : i_ctl.x;
        end else if (!i_ctl.ins && i_ctl.shift) begin
            r_val <= i_next.val;
        end
    end
endmodule
`default_nettype wire

// ----- sv/sss_div.sv -----
`default_nettype none
module sss_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sss_pkg::NUM_W-1:0]   i_num,
    input  wire logic [sss_pkg::DEN_W-1:0]   i_den,
    output sss_pkg::t_unit_stat              o_stat,
    output logic [sss_pkg::NUM_W-1:0]        o_quo,
    output logic [sss_pkg::DEN_W-1:0]        o_rem
);
    localparam int STEP_W = $clog2(sss_pkg::NUM_W + 1);

    logic [sss_pkg::NUM_W-1:0] r_quo;
    logic [sss_pkg::DEN_W-1:0] r_rem;
    logic [sss_pkg::DEN_W-1:0] r_den;
    logic [STEP_W-1:0]         r_step;
    logic                      r_busy;
    logic                      r_done;
    logic [sss_pkg::DEN_W:0]   w_sh;
    logic                      w_ge;
    logic [sss_pkg::DEN_W:0]   w_nrem;

    assign w_sh = {r_rem, r_quo[sss_pkg::NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};
    assign w_nrem = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quo = r_quo;
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(sss_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_nrem[sss_pkg::DEN_W-1:0];
            r_quo <= {r_quo[sss_pkg::NUM_W-2:0], w_ge};
        end
    end
endmodule
`default_nettype wire

// ----- sv/sss_sqrt.sv -----
`default_nettype none
module sss_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output sss_pkg::t_unit_stat o_stat,
    output logic [31:0]      o_root
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_t;

    assign w_t = r_r + r_bit;
    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_root = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one result bit per step, bit walks down by two
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= w_t) begin
                r_v <= r_v - w_t;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

// ----- sv/sample_set_statistics_top.sv -----
// Samples load one per cycle, while idle, into a sorted chain of cells (insert in the accept cycle).
// After the marked sample: a mean divide, a readout pass over the chain, a variance
// divide and a 32-step root (both skipped for fewer than two samples, the root also
// when the variance exceeds 64 bits), then the result goes to the output register.
// Input is stalled from the marked sample until the result is in the output register.
// Synchronous active-low reset empties the chain and sets the fraction to one half.
`default_nettype none
`include "sample_set_statistics_top_macros.svh"
module sample_set_statistics_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sss_pkg::t_in   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output sss_pkg::t_out       o_out_data,
    input  wire logic           i_out_stall,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [0:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int N = sss_pkg::MAX_SAMPLES;
    localparam int CW = sss_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVM, S_MWAIT, S_PASS, S_DRAIN, S_NQ, S_SUB,
        S_DIVV, S_VWAIT, S_SWAIT, S_FIN
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_cnt;
    logic signed [sss_pkg::SUM_W-1:0] r_sum;
    logic                            r_drop;
    logic [sss_pkg::PCT_W-1:0]       r_pct_cfg;
    logic                            r_neg;
    logic signed [31:0]              r_mean;
    logic [CW-1:0]                   r_rem;
    logic [CW-1:0]                   r_lo;
    logic [15:0]                     r_frac;
    logic                            r_usehi;
    logic [CW-1:0]                   r_idx;
    logic [63:0]                     r_sq;
    logic                            r_sq_v;
    logic [sss_pkg::Q_W-1:0]         r_q;
    logic signed [31:0]              r_m0, r_m1, r_plo, r_phi, r_min, r_max;
    logic [sss_pkg::NUM_W-1:0]       r_nq;
    logic [sss_pkg::DEN_W-1:0]       r_rsq;
    logic [48:0]                     r_pm;
    logic [sss_pkg::NUM_W-1:0]       r_num;
    logic signed [31:0]              r_med, r_pctv;
    logic [31:0]                     r_std;
    sss_pkg::t_out                   r_out;
    logic                            r_ov;

    sss_pkg::t_cell_link             w_link [0:N+1];
    sss_pkg::t_cell_ctl              w_ctl;
    logic                            w_acc, w_full, w_load_out;
    logic [sss_pkg::PCT_W-1:0]       w_pclamp;
    logic [sss_pkg::PCT_W+CW-1:0]    w_pos;
    logic [CW:0]                     w_lo_ext;
    logic [sss_pkg::SUM_W-1:0]       w_abs_sum;
    logic signed [31:0]              w_tap;
    logic signed [32:0]              w_d;
    logic [31:0]                     w_mag;
    logic [32:0]                     w_diff;
    logic signed [32:0]              w_ms;
    logic [CW-1:0]                   w_half;
    logic [sss_pkg::DEN_W-1:0]       w_den;
    logic                            w_div_start, w_sq_start;
    logic [sss_pkg::NUM_W-1:0]       w_div_num, w_quo;
    logic [sss_pkg::DEN_W-1:0]       w_div_den, w_drem;
    sss_pkg::t_unit_stat             w_div_st, w_sq_st;
    logic [31:0]                     w_root;
    logic [31:0]                     w_q32;

    // chain ends: a permanently filled slot below cell 0, an empty one above the top
    assign w_link[0]   = '{val: '0, valid: 1'b1, gt: 1'b0};
    assign w_link[N+1] = '{val: '0, valid: 1'b0, gt: 1'b0};

    assign w_acc  = i_in_valid && !o_in_stall;
    assign w_full = w_link[N].valid;
    assign w_ctl  = '{ins: w_acc && !w_full, shift: r_state == S_PASS,
                      x: i_in_data.sample_value};

    for (genvar g = 0; g < N; g++) begin : g_cell
        sss_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_prev (w_link[g]),
            .i_next (w_link[g+2]),
            .o_self (w_link[g+1])
        );
    end

    assign w_pclamp  = (r_pct_cfg > sss_pkg::PCT_ONE) ? sss_pkg::PCT_ONE : r_pct_cfg;
    assign w_pos     = (sss_pkg::PCT_W+CW)'(w_pclamp) * (sss_pkg::PCT_W+CW)'(r_cnt - 1'b1);
    assign w_lo_ext  = (CW+1)'(w_pos >> 16);
    assign w_abs_sum = r_sum[sss_pkg::SUM_W-1] ? sss_pkg::SUM_W'(-r_sum)
                                              : sss_pkg::SUM_W'(r_sum);
    assign w_tap  = w_link[1].val;
    assign w_d    = {w_tap[31], w_tap} - {r_mean[31], r_mean};
    assign w_mag  = w_d[32] ? 32'(-w_d) : w_d[31:0];
    assign w_diff = {r_phi[31], r_phi} - {r_plo[31], r_plo};
    assign w_ms   = {r_m0[31], r_m0} + {r_m1[31], r_m1};
    assign w_half = r_cnt >> 1;
    assign w_den  = sss_pkg::DEN_W'(r_cnt) * sss_pkg::DEN_W'(r_cnt - 1'b1);
    assign w_q32  = w_quo[31:0];

    assign w_div_start = (r_state == S_DIVM) || (r_state == S_DIVV);
    assign w_div_num   = (r_state == S_DIVM) ? sss_pkg::NUM_W'(w_abs_sum) : r_num;
    assign w_div_den   = (r_state == S_DIVM) ? sss_pkg::DEN_W'(r_cnt) : w_den;
    assign w_sq_start  = (r_state == S_VWAIT) && w_div_st.done &&
                         (w_quo[sss_pkg::NUM_W-1:64] == '0);

    sss_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_stat (w_div_st),
        .o_quo  (w_quo),
        .o_rem  (w_drem)
    );

    sss_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start),
        .i_val  (w_quo[63:0]),
        .o_stat (w_sq_st),
        .o_root (w_root)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign w_load_out  = (r_state == S_FIN) && (!r_ov || !i_out_stall);

    assign pready = 1'b1;
    assign prdata = (paddr == sss_pkg::ADDR_PCT) ? 32'(r_pct_cfg) : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct_cfg <= sss_pkg::PCT_RESET;
        end else if (psel && penable && pwrite) begin
            r_pct_cfg <= pwdata[sss_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
            r_sq_v  <= 1'b0;
        end else begin
            r_sq_v <= (r_state == S_PASS);
            if (r_sq_v) r_q <= r_q + sss_pkg::Q_W'(r_sq);
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (!w_full) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_sum <= r_sum + sss_pkg::SUM_W'(i_in_data.sample_value);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_in_data.last_sample) r_state <= S_DIVM;
                    end
                end
                S_DIVM: begin
                    r_neg   <= r_sum[sss_pkg::SUM_W-1];
                    r_lo    <= CW'(w_lo_ext);
                    r_frac  <= w_pos[15:0];
                    r_usehi <= (w_pos[15:0] != 16'h0) &&
                               ((w_lo_ext + 1'b1) < {1'b0, r_cnt});
                    r_q     <= '0;
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_div_st.done) begin
                        r_mean  <= r_neg ? -w_q32 : w_q32;
                        r_rem   <= CW'(w_drem);
                        r_idx   <= '0;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_sq <= 64'(w_mag) * 64'(w_mag);
                    if (r_idx == w_half - 1'b1) r_m0 <= w_tap;
                    if (r_idx == w_half) r_m1 <= w_tap;
                    if (r_idx == r_lo) r_plo <= w_tap;
                    if (r_idx == r_lo + 1'b1) r_phi <= w_tap;
                    if (r_idx == '0) r_min <= w_tap;
                    if (r_idx == r_cnt - 1'b1) begin
                        r_max   <= w_tap;
                        r_state <= S_DRAIN;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DRAIN: r_state <= S_NQ;
                S_NQ: begin
                    r_nq    <= sss_pkg::NUM_W'(r_q) * sss_pkg::NUM_W'(r_cnt);
                    r_rsq   <= sss_pkg::DEN_W'(r_rem) * sss_pkg::DEN_W'(r_rem);
                    r_pm    <= 49'(w_diff) * 49'(r_frac);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_num  <= r_nq - sss_pkg::NUM_W'(r_rsq);
                    r_med  <= r_cnt[0] ? r_m1 : w_ms[32:1];
                    r_pctv <= r_usehi ? (r_plo + r_pm[47:16]) : r_plo;
                    if (r_cnt < CW'(2)) begin
                        r_std   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (w_div_st.done) begin
                        if (w_sq_start) begin
                            r_state <= S_SWAIT;
                        end else begin
                            r_std   <= 32'hFFFF_FFFF;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SWAIT: begin
                    if (w_sq_st.done) begin
                        r_std   <= w_root;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load_out) begin
                        r_out <= '{sample_count: 9'(r_cnt), mean_value: r_mean,
                                   median_value: r_med, std_deviation: r_std,
                                   minimum_value: r_min, maximum_value: r_max,
                                   percentile_value: r_pctv, overflow_flag: r_drop};
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SSS_ASSERT_NOW(a_full_top, i_clk, i_rst_n, (r_state == S_IDLE) && (r_cnt == CW'(N)), w_full)
    `SSS_ASSERT_NOW(a_pass_nonempty, i_clk, i_rst_n, r_state == S_PASS, w_link[1].valid)
    `SSS_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, w_load_out, r_ov && (r_cnt == '0) && !w_link[1].valid)
endmodule
`default_nettype wire

// ----- tb/sample_set_statistics_top_checker.sv -----
`default_nettype none
module sample_set_statistics_top_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sss_pkg::t_in   i_in_data,
    input  wire logic           i_in_stall,
    input  wire logic           i_out_valid,
    input  wire sss_pkg::t_out  i_out_data,
    input  wire logic           i_out_stall,
    input  wire logic           i_psel,
    input  wire logic           i_penable,
    input  wire logic           i_pwrite,
    input  wire logic [0:0]     i_paddr,
    input  wire logic [31:0]    i_pwdata,
    input  wire logic           i_pready,
    output int                  o_fail_count,
    output int                  o_pending_stats
);
    timeunit 1ns;
    timeprecision 1ps;

    int             sorted_samples[$];
    longint         sample_sum;
    bit             samples_dropped;
    logic [16:0]    pct_fraction;
    sss_pkg::t_out  expected_stats[$];

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[31:0];
    endfunction

    // exact variance: (n*sum(d^2) - (sum d)^2) / (n*(n-1)), d against truncated mean
    function automatic logic [31:0] deviation_of(longint mean);
        logic [127:0] acc;
        logic [127:0] dsq;
        logic [63:0]  mag;
        longint       d;
        longint       dsum;
        int           n;
        n = sorted_samples.size();
        if (n < 2) return 0;
        acc = 0;
        dsum = 0;
        foreach (sorted_samples[i]) begin
            d = longint'(sorted_samples[i]) - mean;
            mag = (d < 0) ? -d : d;
            dsum += d;
            acc = acc + 128'(mag) * 128'(mag);
        end
        mag = (dsum < 0) ? -dsum : dsum;
        dsq = 128'(mag) * 128'(mag);
        acc = acc * 128'(n) - dsq;
        acc = acc / 128'(n * (n - 1));
        if (acc[127:64] != 0) return 32'hFFFF_FFFF;
        return floor_root(acc[63:0]);
    endfunction

    function automatic sss_pkg::t_out stats_of_set();
        sss_pkg::t_out r;
        int     n;
        longint mean;
        longint pos;
        longint lo;
        longint fr;
        longint pct;
        longint diff;
        longint p;
        n = sorted_samples.size();
        mean = sample_sum / longint'(n);
        r.sample_count = n[8:0];
        r.mean_value = mean[31:0];
        if (n % 2) begin
            r.median_value = sorted_samples[n / 2];
        end else begin
            pos = longint'(sorted_samples[n / 2 - 1]) + longint'(sorted_samples[n / 2]);
            pos = pos >>> 1;
            r.median_value = pos[31:0];
        end
        r.std_deviation = deviation_of(mean);
        r.minimum_value = sorted_samples[0];
        r.maximum_value = sorted_samples[n - 1];
        // fractions above one clamp to the maximum
        p = (pct_fraction > sss_pkg::PCT_ONE) ? longint'(sss_pkg::PCT_ONE)
                                              : longint'(pct_fraction);
        pos = p * longint'(n - 1);
        lo = pos >> 16;
        fr = pos & 64'hFFFF;
        if (lo >= n) lo = n - 1;
        if (fr == 0 || lo + 1 >= n) begin
            pct = sorted_samples[lo];
        end else begin
            diff = longint'(sorted_samples[lo + 1]) - longint'(sorted_samples[lo]);
            pct = longint'(sorted_samples[lo]) + ((diff * fr) >>> 16);
        end
        r.percentile_value = pct[31:0];
        r.overflow_flag = samples_dropped;
        return r;
    endfunction

    task automatic add_sample(int x);
        int k;
        if (sorted_samples.size() < sss_pkg::MAX_SAMPLES) begin
            k = sorted_samples.size();
            while (k > 0 && sorted_samples[k - 1] > x) k--;
            sorted_samples.insert(k, x);
            sample_sum += x;
        end else begin
            samples_dropped = 1;
        end
    endtask

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t mismatch %s: expected %h, got %h", $realtime, name, e, a);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending_stats = 0;
        sample_sum = 0;
        samples_dropped = 0;
        pct_fraction = sss_pkg::PCT_RESET;
    end

    always @(posedge i_clk) begin
        sss_pkg::t_out e;
        if (!i_rst_n) begin
            sorted_samples.delete();
            sample_sum = 0;
            samples_dropped = 0;
            pct_fraction = sss_pkg::PCT_RESET;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == sss_pkg::ADDR_PCT)
                pct_fraction = i_pwdata[16:0];
            if (i_out_valid && !i_out_stall) begin
                if (expected_stats.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t unexpected result %h", $realtime, i_out_data);
                end else begin
                    e = expected_stats.pop_front();
                    check_field("sample_count", e.sample_count, i_out_data.sample_count);
                    check_field("mean_value", e.mean_value, i_out_data.mean_value);
                    check_field("median_value", e.median_value, i_out_data.median_value);
                    check_field("std_deviation", e.std_deviation, i_out_data.std_deviation);
                    check_field("minimum_value", e.minimum_value, i_out_data.minimum_value);
                    check_field("maximum_value", e.maximum_value, i_out_data.maximum_value);
                    check_field("percentile_value", e.percentile_value,
                                i_out_data.percentile_value);
                    check_field("overflow_flag", e.overflow_flag, i_out_data.overflow_flag);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                add_sample(i_in_data.sample_value);
                if (i_in_data.last_sample) begin
                    expected_stats.insert(expected_stats.size(), stats_of_set());
                    sorted_samples.delete();
                    sample_sum = 0;
                    samples_dropped = 0;
                end
            end
        end
        o_pending_stats = expected_stats.size();
    end
endmodule
`default_nettype wire

// ----- tb/sample_set_statistics_top_test.sv -----
`default_nettype none
module sample_set_statistics_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    sss_pkg::t_in   i_in_data;
    logic           o_in_stall;
    logic           o_out_valid;
    sss_pkg::t_out  o_out_data;
    logic           i_out_stall;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [0:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int  fail_count;
    int  pending_stats;
    int  quiet_cycles;
    int  samples_sent;
    bit  calm;
    int  set_base;

    sample_set_statistics_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sample_set_statistics_top_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .i_in_stall(o_in_stall),
        .i_out_valid(o_out_valid), .i_out_data(o_out_data), .i_out_stall(i_out_stall),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending_stats(pending_stats)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < 9);

    // watchdog: cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(int x, bit last);
        if (!calm && $urandom_range(99) < 9) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_in_data.sample_value = x;
        i_in_data.last_sample = last;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        @(negedge i_clk);
    endtask

    function automatic int pick_value(int style);
        case (style)
            0: return $urandom;
            1: return set_base + int'($urandom_range(0, 2000)) - 1000;
            default: begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(int n, int style);
        set_base = $urandom;
        for (int i = 0; i < n; i++) send_sample(pick_value(style), i == n - 1);
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (pending_stats != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_fraction(logic [16:0] v);
        psel = 1;
        pwrite = 1;
        paddr = sss_pkg::ADDR_PCT;
        pwdata = 32'(v) | ({$urandom} & 32'hFFFE_0000);
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    initial begin
        logic [16:0] fractions[6];
        int n;
        fractions = '{17'h0, sss_pkg::PCT_ONE, 17'h1FFFF, 17'h1, 17'h0C000, 17'h0};
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = sss_pkg::ADDR_PCT;
        pwdata = 0;
        calm = 0;
        quiet_cycles = 0;
        samples_sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // directed sets at the reset fraction
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(32'h8000_0000, 1);
        send_sample(32'h8000_0000, 0);
        send_sample(32'h7FFF_FFFF, 1);
        send_sample(-3, 0);
        send_sample(-3, 0);
        send_sample(4, 0);
        send_sample(-8, 1);
        send_set(5, 2);
        send_set(6, 2);
        drain();

        // one full store plus drops, with the marked sample itself dropped
        write_fraction(fractions[0]);
        send_set(sss_pkg::MAX_SAMPLES + 3, 1);
        send_set(sss_pkg::MAX_SAMPLES, 0);
        drain();

        fractions[5] = $urandom_range(0, 17'h1FFFF);
        for (int ph = 1; ph < 6; ph++) begin
            write_fraction(fractions[ph]);
            calm = (ph == 3);
            while (samples_sent < 500 + 100 * ph) begin
                if ($urandom_range(99) < 2)
                    n = $urandom_range(sss_pkg::MAX_SAMPLES - 2, sss_pkg::MAX_SAMPLES + 4);
                else n = $urandom_range(1, 12);
                send_set(n, $urandom_range(2));
            end
            drain();
        end
        calm = 0;

        if (fail_count == 0 && pending_stats == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
